/* src/connection_id_table_assert.svh */
// Assertion macros for the connection ID table checker.
// Both sample on the rising edge of clk and stay quiet during reset.
`ifndef CONNECTION_ID_TABLE_ASSERT_SVH
`define CONNECTION_ID_TABLE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CIT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("connection_id_table check failed");

// The consequent holds in the cycle after the antecedent.
`define CIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("connection_id_table check failed");

`endif

/* src/cit_pkg.sv */
// ----------------------------------------------------------------------------
// cit_pkg
// Shared constants, command codes and the beat type that travels along the
// row of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cit_pkg;

	localparam int SLOT_COUNT_DEF   = 16;
	localparam int MAX_ID_BYTES_DEF = 20;
	localparam int ID_BYTES_LIMIT   = 20;
	localparam int ID_BITS_LIMIT    = ID_BYTES_LIMIT * 8;

	localparam logic [2:0] CMD_FIND   = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_REKEY  = 3'd3;
	localparam logic [2:0] CMD_ALT2   = 3'd4;

	// One command beat as it moves from cell to cell.
	typedef struct packed {
		logic                     valid;
		logic [2:0]               cmd;
		logic [7:0]               idx;
		logic [4:0]               len;
		logic [ID_BITS_LIMIT-1:0] data;
		logic                     done;
		logic                     ok;
		logic [7:0]               slot;
	} beat_t;

endpackage

`default_nettype wire

/* src/cit_cell.sv */
// ----------------------------------------------------------------------------
// cit_cell
// One slot of the table. Holds the live flag, the primary and both alternate
// IDs, acts on the passing beat if no earlier cell has claimed it, and hands
// the beat on to the next cell through its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_cell #(
	parameter int IDX          = 0,
	parameter int MAX_ID_BYTES = cit_pkg::MAX_ID_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cit_pkg::beat_t beat_i,
	output cit_pkg::beat_t      beat_q
);

	localparam int IdW = MAX_ID_BYTES * 8;

	logic           live_q;
	logic [4:0]     plen_q;
	logic [4:0]     a1len_q;
	logic [4:0]     a2len_q;
	logic [IdW-1:0] pri_q;
	logic [IdW-1:0] alt1_q;
	logic [IdW-1:0] alt2_q;

	logic [IdW-1:0] want;
	logic [IdW-1:0] mask;
	logic           act;
	logic           here;
	logic           len_ok;
	logic           pri_eq;
	logic           alt1_eq;
	logic           alt2_eq;
	logic           claim;
	logic           ok;
	logic           do_insert;
	logic           do_remove;
	logic           do_rekey;
	logic           do_alt2;
	cit_pkg::beat_t beat_d;

	assign want   = beat_i.data[IdW-1:0];
	assign act    = beat_i.valid && !beat_i.done;
	assign here   = (beat_i.idx == 8'(IDX));
	assign len_ok = (beat_i.len <= 5'(MAX_ID_BYTES));

	// Byte mask over the requested length.
	always_comb begin
		for (int k = 0; k < MAX_ID_BYTES; k++) begin
			mask[k*8 +: 8] = (5'(k) < beat_i.len) ? 8'hFF : 8'h00;
		end
	end

	// Compare the key against each stored ID over its length.
	assign pri_eq  = (plen_q == beat_i.len) && (((pri_q ^ want) & mask) == '0);
	assign alt1_eq = (a1len_q != 5'd0) && (a1len_q == beat_i.len)
		&& (((alt1_q ^ want) & mask) == '0);
	assign alt2_eq = (a2len_q != 5'd0) && (a2len_q == beat_i.len)
		&& (((alt2_q ^ want) & mask) == '0);

	// Decide whether this cell takes the beat.
	always_comb begin
		claim     = 1'b0;
		ok        = 1'b0;
		do_insert = 1'b0;
		do_remove = 1'b0;
		do_rekey  = 1'b0;
		do_alt2   = 1'b0;
		if (act) begin
			unique case (beat_i.cmd)
				cit_pkg::CMD_FIND: begin
					claim = live_q && (pri_eq || alt1_eq || alt2_eq);
					ok    = claim;
				end
				cit_pkg::CMD_INSERT: begin
					do_insert = !live_q && len_ok;
					claim     = do_insert;
					ok        = do_insert;
				end
				cit_pkg::CMD_REMOVE: begin
					do_remove = here;
					claim     = here;
					ok        = here;
				end
				cit_pkg::CMD_REKEY: begin
					do_rekey = here && len_ok;
					claim    = here;
					ok       = do_rekey;
				end
				cit_pkg::CMD_ALT2: begin
					do_alt2 = here && len_ok;
					claim   = here;
					ok      = do_alt2;
				end
				default: begin
					claim = 1'b0;
				end
			endcase
		end
	end

	// Live flag and alternate lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= 1'b0;
			a1len_q <= 5'd0;
			a2len_q <= 5'd0;
		end else begin
			if (do_insert) begin
				live_q  <= 1'b1;
				a1len_q <= 5'd0;
				a2len_q <= 5'd0;
			end
			if (do_remove) begin
				live_q <= 1'b0;
			end
			if (do_rekey) begin
				a1len_q <= plen_q;
			end
			if (do_alt2) begin
				a2len_q <= beat_i.len;
			end
		end
	end

	// ID bytes and primary length.
	always_ff @(posedge clk) begin
		if (do_insert || do_rekey) begin
			pri_q  <= want;
			plen_q <= beat_i.len;
		end
		if (do_rekey) begin
			alt1_q <= pri_q;
		end
		if (do_alt2) begin
			alt2_q <= want;
		end
	end

	// Mark the beat as taken when this cell claims it.
	always_comb begin
		beat_d = beat_i;
		if (claim) begin
			beat_d.done = 1'b1;
			beat_d.ok   = ok;
			beat_d.slot = (ok && (beat_i.cmd == cit_pkg::CMD_FIND
				|| beat_i.cmd == cit_pkg::CMD_INSERT)) ? 8'(IDX) : 8'd0;
		end
	end

	// Hand the beat on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else begin
			beat_q <= beat_d;
		end
	end

endmodule

`default_nettype wire

/* src/connection_id_table.sv */
// Commands are taken one at a time: a new command is refused until the result
// of the last one has been taken. The command walks the row of slot cells, one
// cell per cycle, and the result is registered after the last cell.
// Reset clears every live flag and alternate length at once; no clearing pass.
// ----------------------------------------------------------------------------
// connection_id_table
// Connection ID lookup table built as a row of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_id_table #(
	parameter int SLOT_COUNT   = cit_pkg::SLOT_COUNT_DEF,
	parameter int MAX_ID_BYTES = cit_pkg::MAX_ID_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  slot_index,
	input  wire logic [4:0]  id_length,
	input  wire logic [63:0] id_bytes_low,
	input  wire logic [63:0] id_bytes_mid,
	input  wire logic [31:0] id_bytes_high,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             success,
	output logic [3:0]       slot_number
);

	cit_pkg::beat_t chain [SLOT_COUNT+1];

	logic       busy_q;
	logic       out_valid_q;
	logic       success_q;
	logic [3:0] slot_q;

	assign in_ready    = !busy_q;
	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign slot_number = slot_q;

	// Beat entering the first cell.
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = in_valid && in_ready;
		chain[0].cmd   = command;
		chain[0].idx   = slot_index;
		chain[0].len   = id_length;
		chain[0].data  = {id_bytes_high, id_bytes_mid, id_bytes_low};
	end

	// Row of slot cells.
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		cit_cell #(
			.IDX          (i),
			.MAX_ID_BYTES (MAX_ID_BYTES)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.beat_i (chain[i]),
			.beat_q (chain[i+1])
		);
	end

	// Busy flag and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end
			if (chain[SLOT_COUNT].valid) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
				busy_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[SLOT_COUNT].valid) begin
			success_q <= chain[SLOT_COUNT].ok;
			slot_q    <= chain[SLOT_COUNT].slot[3:0];
		end
	end

endmodule

`default_nettype wire

/* src/cit_checker.sv */
// ----------------------------------------------------------------------------
// cit_checker
// Port-level checks on the connection ID table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "connection_id_table_assert.svh"

module cit_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       success,
	input wire logic [3:0] slot_number
);

	// A waiting result stays offered.
	`CIT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// Only one command is in flight.
	`CIT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// No new command while a result waits.
	`CIT_ASSERT_SAME(a_no_take_while_out, out_valid, !in_ready)
	// A failed command reports slot zero.
	`CIT_ASSERT_SAME(a_fail_slot_zero, out_valid && !success, slot_number == 4'd0)

endmodule

bind connection_id_table cit_checker u_cit_checker (.*);

`default_nettype wire
